// ===== src/lav_pkg.sv =====
// Shared types and constants for the camera view matrix block.
// Depends on nothing; every other file of the block imports it.
package lav_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int ACC_W   = 64;
  localparam int TRANS_W = 36;
  localparam int ROW_W   = 2;
  // Normalized magnitudes carry exactly this many significant bits.
  localparam int MAG_W   = 31;
  // One result bit per step of the square root over a 64-bit radicand.
  localparam int SQRT_STEPS = ACC_W / 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // One camera setup as it travels from the front part to the back part.
  typedef struct packed {
    coord_t [2:0] eye;
    coord_t [2:0] up;
    diff_t  [2:0] diff;
    logic         diff_zero;
  } cam_t;

endpackage

// ===== src/lav_front.sv =====
// Front part: takes one camera setup per transaction, forms eye - target
// and flags the case where the two points coincide. Uses lav_pkg.
module lav_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    eye_x_i,
  input  logic signed [31:0]    eye_y_i,
  input  logic signed [31:0]    eye_z_i,
  input  logic signed [31:0]    target_x_i,
  input  logic signed [31:0]    target_y_i,
  input  logic signed [31:0]    target_z_i,
  input  logic signed [31:0]    up_x_i,
  input  logic signed [31:0]    up_y_i,
  input  logic signed [31:0]    up_z_i,
  output logic                  cam_valid_o,
  input  logic                  cam_ready_i,
  output lav_pkg::cam_t         cam_o
);
  import lav_pkg::*;

  coord_t eye   [3];
  coord_t tgt   [3];
  cam_t   cam_d;
  cam_t   cam_q;
  logic   valid_q;

  assign eye[0] = eye_x_i;
  assign eye[1] = eye_y_i;
  assign eye[2] = eye_z_i;
  assign tgt[0] = target_x_i;
  assign tgt[1] = target_y_i;
  assign tgt[2] = target_z_i;

  always_comb begin
    cam_d.up[0] = up_x_i;
    cam_d.up[1] = up_y_i;
    cam_d.up[2] = up_z_i;
    for (int i = 0; i < 3; i++) begin
      cam_d.eye[i]  = eye[i];
      cam_d.diff[i] = {eye[i][COORD_W-1], eye[i]} - {tgt[i][COORD_W-1], tgt[i]};
    end
    cam_d.diff_zero = (eye[0] == tgt[0]) && (eye[1] == tgt[1]) && (eye[2] == tgt[2]);
  end

  assign in_ready_o  = !valid_q || cam_ready_i;
  assign cam_valid_o = valid_q;
  assign cam_o       = cam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (cam_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cam_q <= cam_d;
    end
  end

endmodule

// ===== src/lav_queue.sv =====
// Two-entry queue of camera setups between the front and back parts.
// Uses lav_pkg for the entry type.
module lav_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  lav_pkg::cam_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output lav_pkg::cam_t rd_data_o
);
  import lav_pkg::*;

  cam_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== src/lav_back.sv =====
// Back part: normalizes, crosses and projects one camera setup with a
// shared multiplier, square root and divider, and holds the output register.
// Uses lav_pkg.
module lav_back #(
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cam_valid_i,
  output logic                cam_ready_o,
  input  lav_pkg::cam_t       cam_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          row_index_o,
  output logic signed [31:0]  col0_o,
  output logic signed [31:0]  col1_o,
  output logic signed [31:0]  col2_o,
  output logic signed [35:0]  translation_o,
  output logic                degenerate_o,
  output logic                last_row_o
);
  import lav_pkg::*;

  localparam int UF    = UNIT_FRAC_BITS;
  localparam int QW    = UF + 1;
  localparam int NUMW  = QW + MAG_W;
  localparam int CNT_W = 5;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NCHK   = 4'd1;
  localparam logic [3:0] ST_NSHIFT = 4'd2;
  localparam logic [3:0] ST_SQMUL  = 4'd3;
  localparam logic [3:0] ST_SQACC  = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_DINIT  = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_DDONE  = 4'd8;
  localparam logic [3:0] ST_MUL    = 4'd9;
  localparam logic [3:0] ST_ACC    = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  localparam logic [1:0] PH_CROSS = 2'd0;
  localparam logic [1:0] PH_VROW  = 2'd1;
  localparam logic [1:0] PH_DOT   = 2'd2;

  localparam logic [ACC_W-1:0] ONE  = ACC_W'(1) << UF;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (UF - 1);

  function automatic logic [1:0] nxt1(input logic [1:0] i);
    nxt1 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] i);
    nxt2 = (i == 2'd0) ? 2'd2 : i - 2'd1;
  endfunction

  // Control.
  logic [3:0]       state_q;
  logic [1:0]       idx_q;
  logic [1:0]       term_q;
  logic [1:0]       ph_q;
  logic             nsel_q;
  logic [CNT_W-1:0] cnt_q;
  logic             degen_q;
  logic             out_valid_q;

  // Datapath.
  logic signed [ACC_W-1:0] vec_q [3];
  logic [ACC_W-1:0]        mag_q [3];
  coord_t                  eye_q [3];
  coord_t                  up_q  [3];
  coord_t                  w_q   [3];
  coord_t                  u_q   [3];
  coord_t                  v_q   [3];
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        rad_q;
  logic [31:0]             root_q;
  logic [33:0]             srem_q;
  logic [32:0]             drem_q;
  logic [QW-1:0]           dlow_q;
  logic [QW-1:0]           quo_q;
  logic signed [TRANS_W-1:0] tr_q;

  logic [ROW_W-1:0]          row_index_q;
  coord_t                    col_q [3];
  logic signed [TRANS_W-1:0] trans_q;
  logic                      degen_out_q;
  logic                      last_q;

  // Combinational helpers.
  logic [ACC_W-1:0]        orv;
  logic                    shr;
  logic                    shl;
  logic                    vec_zero;
  logic [1:0]              ia;
  logic [1:0]              ib;
  logic                    sub;
  logic                    last_term;
  coord_t                  opa;
  coord_t                  opb;
  coord_t                  mul_a;
  coord_t                  mul_b;
  logic signed [ACC_W-1:0] mul_res;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        rnd;
  logic [ACC_W-1:0]        rnd_c;
  coord_t                  vval;
  logic signed [TRANS_W-1:0] tval;
  logic [33:0]             sq_shift;
  logic [33:0]             sq_trial;
  logic                    sq_ge;
  logic [32:0]             dv_shift;
  logic                    dv_ge;
  logic [NUMW-1:0]         num;
  coord_t                  qs;
  logic                    out_load;

  assign orv      = mag_q[0] | mag_q[1] | mag_q[2];
  assign shr      = |orv[ACC_W-1:MAG_W];
  assign shl      = !shr && !orv[MAG_W-1];
  assign vec_zero = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0);

  // Operand pick for the cross products and dot products.
  always_comb begin
    sub       = 1'b0;
    last_term = (term_q == 2'd1);
    if (term_q == 2'd0) begin
      ia = nxt1(idx_q);
      ib = nxt2(idx_q);
    end else begin
      ia  = nxt2(idx_q);
      ib  = nxt1(idx_q);
      sub = 1'b1;
    end
    case (ph_q)
      PH_CROSS: begin
        opa = up_q[ia];
        opb = w_q[ib];
      end
      PH_VROW: begin
        opa = w_q[ia];
        opb = u_q[ib];
      end
      default: begin
        ia        = term_q;
        ib        = term_q;
        sub       = 1'b0;
        last_term = (term_q == 2'd2);
        case (idx_q)
          2'd0:    opa = u_q[term_q];
          2'd1:    opa = v_q[term_q];
          default: opa = w_q[term_q];
        endcase
        opb = eye_q[ib];
      end
    endcase
  end

  // The one shared multiplier; its product is always registered.
  always_comb begin
    if (state_q == ST_SQMUL) begin
      mul_a = $signed({1'b0, mag_q[idx_q][MAG_W-1:0]});
      mul_b = mul_a;
    end else begin
      mul_a = opa;
      mul_b = opb;
    end
  end
  assign mul_res = mul_a * mul_b;

  assign acc_sum = ((term_q == 2'd0) ? '0 : acc_q) + (sub ? -prod_q : prod_q);

  // Rounding half away from zero, clamp for v, negation for translation.
  assign acc_mag = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
  assign rnd     = (acc_mag + HALF) >> UF;
  assign rnd_c   = (rnd > ONE) ? ONE : rnd;
  assign vval    = acc_q[ACC_W-1] ? -COORD_W'(rnd_c) : COORD_W'(rnd_c);
  assign tval    = acc_q[ACC_W-1] ? TRANS_W'(rnd) : -TRANS_W'(rnd);

  // Square root, one result bit per step.
  assign sq_shift = {srem_q[31:0], rad_q[ACC_W-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = (sq_shift >= sq_trial);

  // Divider, one quotient bit per step.
  assign num      = (NUMW'(mag_q[idx_q][MAG_W-1:0]) << UF) + NUMW'(root_q[31:1]);
  assign dv_shift = {drem_q[31:0], dlow_q[QW-1]};
  assign dv_ge    = (dv_shift >= {1'b0, root_q});
  assign qs       = vec_q[idx_q][ACC_W-1] ? -COORD_W'(quo_q) : COORD_W'(quo_q);

  assign out_load    = !out_valid_q || out_ready_i;
  assign cam_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
      term_q  <= 2'd0;
      ph_q    <= PH_CROSS;
      nsel_q  <= 1'b0;
      cnt_q   <= '0;
      degen_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cam_valid_i) begin
            idx_q   <= 2'd0;
            nsel_q  <= 1'b0;
            degen_q <= cam_i.diff_zero;
            state_q <= cam_i.diff_zero ? ST_EMIT : ST_NSHIFT;
          end
        end
        ST_NCHK: begin
          if (vec_zero) begin
            degen_q <= 1'b1;
            idx_q   <= 2'd0;
            state_q <= ST_EMIT;
          end else begin
            nsel_q  <= 1'b1;
            state_q <= ST_NSHIFT;
          end
        end
        ST_NSHIFT: begin
          if (!shr && !shl) begin
            idx_q   <= 2'd0;
            state_q <= ST_SQMUL;
          end
        end
        ST_SQMUL: state_q <= ST_SQACC;
        ST_SQACC: begin
          if (idx_q == 2'd2) begin
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= ST_SQMUL;
          end
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
            idx_q   <= 2'd0;
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(QW - 1)) state_q <= ST_DDONE;
        end
        ST_DDONE: begin
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            term_q  <= 2'd0;
            ph_q    <= nsel_q ? PH_VROW : PH_CROSS;
            state_q <= ST_MUL;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= ST_DINIT;
          end
        end
        ST_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          if (!last_term) begin
            term_q  <= term_q + 2'd1;
            state_q <= ST_MUL;
          end else if (ph_q == PH_CROSS) begin
            term_q <= 2'd0;
            if (idx_q == 2'd2) begin
              state_q <= ST_NCHK;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_MUL;
            end
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (ph_q == PH_VROW) begin
            term_q  <= 2'd0;
            state_q <= ST_MUL;
            if (idx_q == 2'd2) begin
              idx_q <= 2'd0;
              ph_q  <= PH_DOT;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (idx_q == 2'd2) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q  <= idx_q + 2'd1;
              term_q <= 2'd0;
              if (!degen_q) state_q <= ST_MUL;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cam_valid_i) begin
          for (int i = 0; i < 3; i++) begin
            eye_q[i] <= cam_i.eye[i];
            up_q[i]  <= cam_i.up[i];
            vec_q[i] <= ACC_W'($signed(cam_i.diff[i]));
            mag_q[i] <= ACC_W'(cam_i.diff[i][DIFF_W-1] ?
                               (DIFF_W'(0) - cam_i.diff[i]) : cam_i.diff[i]);
          end
        end
      end
      ST_NCHK: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vec_q[i][ACC_W-1] ? (ACC_W'(0) - vec_q[i]) : vec_q[i];
        end
      end
      ST_NSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (shr) begin
            mag_q[i] <= mag_q[i] >> 1;
          end else if (shl) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
        acc_q <= '0;
      end
      ST_SQMUL, ST_MUL: prod_q <= mul_res;
      ST_SQACC: begin
        acc_q  <= acc_q + prod_q;
        rad_q  <= acc_q + prod_q;
        root_q <= '0;
        srem_q <= '0;
      end
      ST_SQRT: begin
        rad_q  <= rad_q << 2;
        srem_q <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
        root_q <= {root_q[30:0], sq_ge};
      end
      ST_DINIT: begin
        drem_q <= 33'(num[NUMW-1:QW]);
        dlow_q <= num[QW-1:0];
        quo_q  <= '0;
      end
      ST_DIV: begin
        drem_q <= dv_ge ? (dv_shift - {1'b0, root_q}) : dv_shift;
        dlow_q <= dlow_q << 1;
        quo_q  <= {quo_q[QW-2:0], dv_ge};
      end
      ST_DDONE: begin
        if (nsel_q) begin
          u_q[idx_q] <= qs;
        end else begin
          w_q[idx_q] <= qs;
        end
      end
      ST_ACC: begin
        acc_q <= acc_sum;
        if (last_term && ph_q == PH_CROSS) vec_q[idx_q] <= acc_sum;
      end
      ST_FIN: begin
        if (ph_q == PH_VROW) begin
          v_q[idx_q] <= vval;
        end else begin
          tr_q <= tval;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          row_index_q <= idx_q;
          degen_out_q <= degen_q;
          last_q      <= (idx_q == 2'd2);
          trans_q     <= degen_q ? '0 : tr_q;
          for (int i = 0; i < 3; i++) begin
            if (degen_q) begin
              col_q[i] <= '0;
            end else begin
              case (idx_q)
                2'd0:    col_q[i] <= u_q[i];
                2'd1:    col_q[i] <= v_q[i];
                default: col_q[i] <= w_q[i];
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = row_index_q;
  assign col0_o        = col_q[0];
  assign col1_o        = col_q[1];
  assign col2_o        = col_q[2];
  assign translation_o = trans_q;
  assign degenerate_o  = degen_out_q;
  assign last_row_o    = last_q;

endmodule

// ===== src/look_at_view_matrix.sv =====
// Top level of the camera view matrix block: front part, queue, back part.
// Depends on lav_pkg, lav_front, lav_queue and lav_back.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_ready_o   eye, target, up (Q16.16)
//   output    out        out_valid_o / out_ready_i row_index, col0..2, translation,
//                                                  degenerate, last_row
//
// Every input transaction yields three output transactions, rows u, v and w.
// In the back part, the work on a camera setup is set by the bit-serial
// square root (32 steps) and the divider (UNIT_FRAC_BITS + 1 steps per
// component), run once for w and once for u, and by the one shared 32x32
// multiplier.
// In the back part, a setup whose eye equals its target goes straight from
// the idle state to the emit state and emits its three rows there. A setup
// whose up vector crosses w to zero still pays the full cost of w.
// Reset is asynchronous and active low and empties the queue and output.
// The front register and the two-entry queue keep taking setups while the
// back part works or the output register waits on out_ready_i.
module look_at_view_matrix #(
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] up_x_i,
  input  logic signed [31:0] up_y_i,
  input  logic signed [31:0] up_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [35:0] translation_o,
  output logic               degenerate_o,
  output logic               last_row_o
);
  import lav_pkg::*;

  // Front register to queue.
  cam_t front_cam;
  logic front_valid;
  logic front_ready;

  // Queue to back part.
  cam_t back_cam;
  logic back_valid;
  logic back_ready;

  // The front part forms eye - target and spots coincident points early,
  // so the back part can skip straight to the all-zero rows.
  lav_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .eye_x_i     (eye_x_i),
    .eye_y_i     (eye_y_i),
    .eye_z_i     (eye_z_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .target_z_i  (target_z_i),
    .up_x_i      (up_x_i),
    .up_y_i      (up_y_i),
    .up_z_i      (up_z_i),
    .cam_valid_o (front_valid),
    .cam_ready_i (front_ready),
    .cam_o       (front_cam)
  );

  lav_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cam),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_cam)
  );

  // The back part pops one setup, computes w, u and v with the translations,
  // and drives the output register one row per transaction.
  lav_back #(
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cam_valid_i   (back_valid),
    .cam_ready_o   (back_ready),
    .cam_i         (back_cam),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_index_o   (row_index_o),
    .col0_o        (col0_o),
    .col1_o        (col1_o),
    .col2_o        (col2_o),
    .translation_o (translation_o),
    .degenerate_o  (degenerate_o),
    .last_row_o    (last_row_o)
  );

endmodule

// ===== test/look_at_view_matrix_test.sv =====
// Self-checking testbench for the camera view matrix block.
// Depends on lav_pkg and look_at_view_matrix, and through it on lav_front, lav_queue and lav_back.
// A directed table comes first, then random camera setups under several idle patterns.
module look_at_view_matrix_test;
  import lav_pkg::*;

  localparam longint UNIT_ONE  = longint'(1) << 30;
  localparam longint COORD_ONE = longint'(1) << 16;
  localparam int     WATCHDOG_LIMIT = 40000;
  localparam int     DRAIN_CYCLES   = 800;
  localparam int     HOLD_CYCLES    = 3000;
  localparam int     RANDOM_ITEMS   = 400;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_DEGENERATE,
    CHECK_IDENTITY
  } check_kind_e;

  // One expected output transaction.
  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2;
    logic [35:0] trans;
    logic        degen;
    logic        last;
  } view_row_t;

  typedef struct {
    longint      eye[3];
    longint      tgt[3];
    longint      up[3];
    check_kind_e kind;
  } camera_case_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  coord_t       eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  coord_t       target_x_i = '0, target_y_i = '0, target_z_i = '0;
  coord_t       up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [1:0]   row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o;
  logic signed [35:0] translation_o;
  logic         degenerate_o;
  logic         last_row_o;

  view_row_t    pending_rows[$];
  camera_case_t camera_table[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_request = 0;

  look_at_view_matrix dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Fixed-point predictor of the view matrix.
  // ---------------------------------------------------------------------

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Bit-serial integer square root, floor of the exact root.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Magnitude divided by 2^sh, rounded half away from zero, sign kept.
  function automatic longint round_away(input longint s, input int sh);
    longint unsigned m;
    m = (magnitude(s) + (longint'(1) << (sh - 1))) >> sh;
    return (s < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_unit(input longint x);
    if (x > UNIT_ONE) return UNIT_ONE;
    if (x < -UNIT_ONE) return -UNIT_ONE;
    return x;
  endfunction

  // Scales to 31 significant bits, then divides by the rounded-down length.
  // Returns 0 for the zero vector.
  function automatic bit unit_vector(input longint v[3], output longint r[3]);
    longint unsigned a[3], m, sum, len, q;
    int bl;
    m = 0;
    sum = 0;
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return 1'b0;
    while (bl < 64 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > 31) a[i] = a[i] >> (bl - 31);
      else a[i] = a[i] << (31 - bl);
      sum += a[i] * a[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (len >> 1)) / len;
      r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void push_row(input int k, input longint b[3], input longint t,
                                   input bit degen);
    view_row_t e;
    e.row   = k[1:0];
    e.c0    = b[0][31:0];
    e.c1    = b[1][31:0];
    e.c2    = b[2][31:0];
    e.trans = t[35:0];
    e.degen = degen;
    e.last  = (k == 2);
    pending_rows.push_back(e);
  endfunction

  // Works out the three rows u, v, w for one camera setup.
  function automatic void predict_view(input longint eye[3], input longint tgt[3],
                                       input longint up[3]);
    longint d[3], cr[3], w[3], u[3], v[3], zero[3];
    longint basis[3][3];
    longint dot;
    bit degen;
    zero = '{0, 0, 0};
    for (int i = 0; i < 3; i++) d[i] = eye[i] - tgt[i];
    degen = !unit_vector(d, w);
    if (!degen) begin
      cr[0] = up[1] * w[2] - up[2] * w[1];
      cr[1] = up[2] * w[0] - up[0] * w[2];
      cr[2] = up[0] * w[1] - up[1] * w[0];
      degen = !unit_vector(cr, u);
    end
    if (degen) begin
      for (int k = 0; k < 3; k++) push_row(k, zero, 0, 1'b1);
      return;
    end
    v[0] = clamp_unit(round_away(w[1] * u[2] - w[2] * u[1], 30));
    v[1] = clamp_unit(round_away(w[2] * u[0] - w[0] * u[2], 30));
    v[2] = clamp_unit(round_away(w[0] * u[1] - w[1] * u[0], 30));
    basis[0] = u;
    basis[1] = v;
    basis[2] = w;
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += basis[k][i] * eye[i];
      push_row(k, basis[k], -round_away(dot, 30), 1'b0);
    end
  endfunction

  // Expectations that can be read straight off the definition.
  function automatic void push_typed(input check_kind_e kind);
    longint zero[3], ex[3], ey[3], ez[3];
    zero = '{0, 0, 0};
    ex = '{UNIT_ONE, 0, 0};
    ey = '{0, UNIT_ONE, 0};
    ez = '{0, 0, UNIT_ONE};
    if (kind == CHECK_DEGENERATE) begin
      for (int k = 0; k < 3; k++) push_row(k, zero, 0, 1'b1);
    end else begin
      push_row(0, ex, 0, 1'b0);
      push_row(1, ey, 0, 1'b0);
      push_row(2, ez, -COORD_ONE, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offers one camera setup and waits for its transaction.
  // ---------------------------------------------------------------------

  task automatic send_camera(input camera_case_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    eye_x_i = c.eye[0][31:0];
    eye_y_i = c.eye[1][31:0];
    eye_z_i = c.eye[2][31:0];
    target_x_i = c.tgt[0][31:0];
    target_y_i = c.tgt[1][31:0];
    target_z_i = c.tgt[2][31:0];
    up_x_i = c.up[0][31:0];
    up_y_i = c.up[1][31:0];
    up_z_i = c.up[2][31:0];
    do @(posedge clk_i); while (!in_ready_o);
    if (c.kind == CHECK_PREDICTED) predict_view(c.eye, c.tgt, c.up);
    else push_typed(c.kind);
    @(negedge clk_i);
  endtask

  function automatic longint full_coord();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint near_coord(input int bits);
    return longint'($signed($urandom())) >>> (32 - bits);
  endfunction

  function automatic camera_case_t make_case(input longint e0, e1, e2, t0, t1, t2,
                                             u0, u1, u2, input check_kind_e kind);
    camera_case_t c;
    c.eye = '{e0, e1, e2};
    c.tgt = '{t0, t1, t2};
    c.up = '{u0, u1, u2};
    c.kind = kind;
    return c;
  endfunction

  // Random camera: mostly ordinary views, with coincident, parallel and zero-up setups mixed in.
  function automatic camera_case_t random_camera();
    camera_case_t c;
    int pick, k;
    longint d[3];
    pick = $urandom_range(99);
    c.kind = CHECK_PREDICTED;
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = (pick < 50) ? full_coord() : near_coord(24);
      c.tgt[i] = (pick < 50) ? full_coord() : near_coord(24);
      c.up[i]  = (pick < 40) ? full_coord() : near_coord(20);
    end
    if (pick < 8) begin
      c.tgt = c.eye;
    end else if (pick < 16) begin
      // Up along the view direction; exactly degenerate only when rounding allows.
      k = $urandom_range(64, 1);
      for (int i = 0; i < 3; i++) begin
        d[i] = ($urandom_range(2) == 0) ? 0 : near_coord(20);
        c.tgt[i] = c.eye[i] - d[i];
        c.up[i] = d[i] * k;
      end
    end else if (pick < 22) begin
      c.up = '{0, 0, 0};
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------

  initial begin
    int held;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_ready_i = 1'b0;
        repeat (held) @(negedge clk_i);
      end
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    view_row_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected output transaction, row %0d", row_index_o);
      end else begin
        e = pending_rows.pop_front();
        if (row_index_o !== e.row || col0_o !== e.c0 || col1_o !== e.c1 ||
            col2_o !== e.c2 || translation_o !== e.trans ||
            degenerate_o !== e.degen || last_row_o !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected row %0d cols %h %h %h trans %h degen %b last %b",
                     e.row, e.c0, e.c1, e.c2, e.trans, e.degen, e.last);
            $display("          actual   row %0d cols %h %h %h trans %h degen %b last %b",
                     row_index_o, col0_o, col1_o, col2_o, translation_o,
                     degenerate_o, last_row_o);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------

  initial begin
    longint mx, mn;
    int drained;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // Directed table: identity view, coincident points, zero and parallel up,
    // extremes of every field.
    camera_table.push_back(make_case(0, 0, COORD_ONE, 0, 0, 0, 0, COORD_ONE, 0,
                                     CHECK_IDENTITY));
    camera_table.push_back(make_case(0, 0, 0, 0, 0, 0, 0, COORD_ONE, 0, CHECK_DEGENERATE));
    camera_table.push_back(make_case(mx, mn, mx, mx, mn, mx, mn, mx, mn, CHECK_DEGENERATE));
    camera_table.push_back(make_case(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, 0, 0, 0,
                                     0, 0, 0, CHECK_DEGENERATE));
    camera_table.push_back(make_case(COORD_ONE, COORD_ONE, COORD_ONE, 0, 0, 0,
                                     2 * COORD_ONE, 2 * COORD_ONE, 2 * COORD_ONE,
                                     CHECK_DEGENERATE));
    camera_table.push_back(make_case(0, 0, 5 * COORD_ONE, 0, 0, 0, 0, 0, -COORD_ONE,
                                     CHECK_DEGENERATE));
    camera_table.push_back(make_case(mx, mx, mx, mn, mn, mn, mn, mn, mx, CHECK_PREDICTED));
    camera_table.push_back(make_case(mn, mn, mn, mx, mx, mx, mx, mx, mn, CHECK_PREDICTED));
    camera_table.push_back(make_case(mx, mn, mx, mn, mx, mn, mx, mx, mx, CHECK_PREDICTED));
    camera_table.push_back(make_case(-1, -1, -1, 0, 0, 0, 1, 0, 0, CHECK_PREDICTED));
    camera_table.push_back(make_case(1, 0, 0, 0, 0, 0, 0, 1, 0, CHECK_PREDICTED));
    camera_table.push_back(make_case(0, 0, 0, 0, 0, 1, mx, 0, 0, CHECK_PREDICTED));
    camera_table.push_back(make_case(mx, mx, mx, 0, 0, 0, COORD_ONE, 0, 0, CHECK_PREDICTED));
    camera_table.push_back(make_case(-3 * COORD_ONE, 7 * COORD_ONE, -COORD_ONE,
                                     COORD_ONE, -2 * COORD_ONE, 4 * COORD_ONE,
                                     0, COORD_ONE, 0, CHECK_PREDICTED));
    camera_table.push_back(make_case(12345, -67890, 13579, -24680, 11111, -99999,
                                     mn, 1, -1, CHECK_PREDICTED));
    camera_table.push_back(make_case(mx, 0, 0, mn, 0, 0, 0, 0, mx, CHECK_PREDICTED));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (camera_table[i]) send_camera(camera_table[i]);

    // Random part in four idle phases; the long receiver hold-off opens phase one.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / (RANDOM_ITEMS / 4))
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          if (n == 0) hold_request = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      send_camera(random_camera());
    end
    in_valid_i = 1'b0;

    while (pending_rows.size() != 0) @(posedge clk_i);
    drained = 0;
    while (drained < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drained++;
    end

    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
